// ===== hw/rtl/fupwm_pkg.sv =====
// Shared constants and helpers for the framed serial PWM dimmer.
// No dependencies; imported by framed_uart_pwm_dimmer.
package fupwm_pkg;

  localparam int CHANNELS  = 4;                    // PWM channels with a stored level
  localparam int LINES     = 4;                    // width of the pwm_lines field
  localparam int LEVEL_N   = (CHANNELS < LINES) ? CHANNELS : LINES;
  localparam int FRAME_LEN = 6;
  localparam int POS_W     = 3;

  localparam logic [7:0] HDR_BYTE = 8'hAA;
  localparam logic [7:0] TRL_BYTE = 8'h55;
  localparam logic [7:0] PHASE_TOP = 8'hFF;
  localparam logic [7:0] LEVEL_RST = 8'hFF;

  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);

  // Request command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // Result kind codes
  localparam logic KIND_PWM = 1'b0;
  localparam logic KIND_TX  = 1'b1;

  // Characters of the error reply "ERROR!"
  function automatic logic [7:0] err_char(input logic [POS_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h45;
      3'd1:    ch = 8'h52;
      3'd2:    ch = 8'h52;
      3'd3:    ch = 8'h4F;
      3'd4:    ch = 8'h52;
      3'd5:    ch = 8'h21;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/framed_uart_pwm_dimmer.sv =====
// Framed serial PWM dimmer: frame checker, echo/error replies and PWM compare.
// Depends on fupwm_pkg.
//
//  channel | handshake            | payload                          | per request
//  --------+----------------------+----------------------------------+----------------
//  request | req_valid/req_ready  | cmd, rx_byte                     | one
//  result  | rsp_valid/rsp_ready  | kind, pwm_lines, tx_byte, last   | zero, one or six
//
// A request is held in an input register and processed once the result register is
// free (empty, or its final result is being taken). A tick gives one result in the
// next cycle; a frame end or a framing error gives a burst of six transmit results,
// each following when the one before is taken; no request is processed until the
// burst's last result is taken. Other bytes give no result. While a result stalls,
// one further request is still taken into the input register. Reset clears the frame
// position, phase and levels (to 255); the frame store is not reset.
module framed_uart_pwm_dimmer (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic       cmd,
  input  logic [7:0] rx_byte,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic       kind,
  output logic [fupwm_pkg::LINES-1:0] pwm_lines,
  output logic [7:0] tx_byte,
  output logic       last
);

  import fupwm_pkg::*;

  // Input register
  logic       s1_valid;
  logic       s1_cmd;
  logic [7:0] s1_byte;

  // Block state
  logic [POS_W-1:0] frame_position;
  logic [7:0]       frame_store [FRAME_LEN];
  logic [7:0]       duty_levels [LEVEL_N];
  logic [7:0]       pwm_phase;

  // Burst control beside the result register
  logic             burst_err;
  logic [POS_W-1:0] burst_idx;

  logic             slot_free;
  logic             s1_move;
  logic             burst_step;
  logic [POS_W-1:0] idx_next;
  logic [7:0]       phase_inc;
  logic [LINES-1:0] lines_next;
  logic             frame_ok;
  logic             frame_adv;
  logic             byte_reply;

  assign slot_free  = !rsp_valid || (rsp_ready && last);
  assign s1_move    = s1_valid && slot_free;
  assign req_ready  = !s1_valid || s1_move;
  assign burst_step = rsp_valid && rsp_ready && !last;
  assign idx_next   = burst_idx + POS_W'(1);

  assign phase_inc  = pwm_phase + 8'd1;
  assign frame_ok   = (frame_position == POS_LAST) && (s1_byte == TRL_BYTE);
  assign frame_adv  = ((frame_position == POS_FIRST) && (s1_byte == HDR_BYTE)) ||
                      ((frame_position >= POS_W'(1)) && (frame_position <= POS_W'(4)));
  assign byte_reply = !frame_adv;

  // Lit (low) while the incremented phase, before its wrap to zero, is below the channel level
  always_comb begin
    lines_next = '1;
    for (int c = 0; c < LINES; c++) begin
      if (c < LEVEL_N) begin
        lines_next[c] = !(phase_inc < duty_levels[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_cmd  <= cmd;
      s1_byte <= rx_byte;
    end
  end

  // Frame store holds raw bytes; no reset
  always_ff @(posedge clk) begin
    if (s1_move && s1_cmd == CMD_BYTE && frame_position < POS_W'(FRAME_LEN)) begin
      frame_store[frame_position] <= s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= POS_FIRST;
      pwm_phase      <= 8'd0;
      for (int c = 0; c < LEVEL_N; c++) begin
        duty_levels[c] <= LEVEL_RST;
      end
    end else if (s1_move) begin
      if (s1_cmd == CMD_TICK) begin
        pwm_phase <= (phase_inc == PHASE_TOP) ? 8'd0 : phase_inc;
      end else if (frame_adv) begin
        frame_position <= frame_position + POS_W'(1);
      end else begin
        frame_position <= POS_FIRST;
        if (frame_ok) begin
          for (int c = 0; c < LEVEL_N; c++) begin
            duty_levels[c] <= frame_store[c + 1];
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= (s1_cmd == CMD_TICK) || byte_reply;
    end else if (rsp_valid && rsp_ready && last) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      burst_idx <= POS_FIRST;
      burst_err <= !frame_ok;
      if (s1_cmd == CMD_TICK) begin
        kind      <= KIND_PWM;
        pwm_lines <= lines_next;
        tx_byte   <= 8'd0;
        last      <= 1'b1;
      end else begin
        kind      <= KIND_TX;
        pwm_lines <= '0;
        tx_byte   <= frame_ok ? frame_store[0] : err_char(POS_FIRST);
        last      <= 1'b0;
      end
    end else if (burst_step) begin
      // advance through the six reply bytes
      burst_idx <= idx_next;
      tx_byte   <= burst_err ? err_char(idx_next) : frame_store[idx_next];
      last      <= (idx_next == POS_LAST);
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    frame_position < POS_W'(FRAME_LEN))
    else $error("frame position out of range");

  a_burst_idx: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> burst_idx < POS_W'(FRAME_LEN))
    else $error("reply index out of range");

  a_tx_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind == KIND_TX |-> last == (burst_idx == POS_LAST))
    else $error("reply last flag misplaced");

  a_pwm_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind == KIND_PWM |-> last && tx_byte == 8'd0)
    else $error("line update malformed");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_byte) && $stable(s1_cmd))
    else $error("held request lost");
`endif

endmodule

// ===== tb/sv/framed_uart_pwm_dimmer_test.sv =====
// Self-checking testbench for framed_uart_pwm_dimmer: frame echo, error replies and PWM lines.
// Depends on fupwm_pkg and the framed_uart_pwm_dimmer RTL; a scoreboard class predicts replies.
module framed_uart_pwm_dimmer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fupwm_pkg::*;

  localparam int          IDLE_LIMIT  = 2000;
  localparam int          TAIL_CYCLES = 20;
  localparam int          ITEM_TARGET = 380;
  localparam int          QUIET_AFTER = 330;
  localparam logic [47:0] ERR_TEXT    = "ERROR!";

  typedef struct packed {
    logic             kind;
    logic [LINES-1:0] lines;
    logic [7:0]       tx;
    logic             last;
  } reply_t;

  class dimmer_scoreboard;
    reply_t           expected_replies[$];
    logic [POS_W-1:0] frame_pos;
    logic [7:0]       frame_bytes [FRAME_LEN];
    logic [7:0]       levels [LINES];
    logic [7:0]       phase;
    int errors, n_ticks, n_wraps, n_echoes, n_rejects, n_checked;

    function new();
      frame_pos = POS_FIRST;
      phase = 8'h00;
      foreach (levels[c]) levels[c] = LEVEL_RST;
      foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
    endfunction

    // Queue six transmit replies, first byte in the top octet.
    function void queue_six(input logic [47:0] text);
      reply_t r;
      for (int k = 0; k < FRAME_LEN; k++) begin
        r.kind  = KIND_TX;
        r.lines = '0;
        r.tx    = text[47 - 8 * k -: 8];
        r.last  = (k == FRAME_LEN - 1);
        expected_replies.push_back(r);
      end
    endfunction

    function void note_request(input logic c, input logic [7:0] b);
      reply_t           r;
      logic [LINES-1:0] lines;
      logic [POS_W-1:0] pos;
      logic [47:0]      echo;
      if (c == CMD_TICK) begin
        phase = phase + 8'd1;
        for (int ch = 0; ch < LINES; ch++)
          lines[ch] = !((ch < CHANNELS) && (phase < levels[ch]));
        if (phase == PHASE_TOP) begin
          phase = 8'h00;
          n_wraps++;
        end
        r.kind  = KIND_PWM;
        r.lines = lines;
        r.tx    = 8'h00;
        r.last  = 1'b1;
        expected_replies.push_back(r);
        n_ticks++;
        return;
      end
      pos = frame_pos;
      if (pos < FRAME_LEN) frame_bytes[pos] = b;
      if (pos == POS_FIRST && b == HDR_BYTE) begin
        frame_pos = POS_FIRST + POS_W'(1);
      end else if (pos > POS_FIRST && pos < POS_LAST) begin
        frame_pos = pos + POS_W'(1);
      end else begin
        frame_pos = POS_FIRST;
        if (pos == POS_LAST && b == TRL_BYTE) begin
          for (int ch = 0; ch < LEVEL_N; ch++) levels[ch] = frame_bytes[ch + 1];
          for (int k = 0; k < FRAME_LEN; k++) echo[47 - 8 * k -: 8] = frame_bytes[k];
          queue_six(echo);
          n_echoes++;
        end else begin
          queue_six(ERR_TEXT);
          n_rejects++;
        end
      end
    endfunction

    function void check_result(input logic k, input logic [LINES-1:0] lines,
                               input logic [7:0] tx, input logic l);
      reply_t want;
      n_checked++;
      if (expected_replies.size() == 0) begin
        $error("unexpected result: kind %0d pwm_lines %h tx_byte %h last %0d", k, lines, tx, l);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      if (k !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, k);
        errors++;
      end
      if (lines !== want.lines) begin
        $error("pwm_lines: expected %h, got %h", want.lines, lines);
        errors++;
      end
      if (tx !== want.tx) begin
        $error("tx_byte: expected %h, got %h", want.tx, tx);
        errors++;
      end
      if (l !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, l);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  logic             cmd = CMD_TICK;
  logic [7:0]       rx_byte = 8'h00;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  logic             kind;
  logic [LINES-1:0] pwm_lines;
  logic [7:0]       tx_byte;
  logic             last;

  dimmer_scoreboard sb;
  bit quiet_tail = 1'b0;
  int n_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int cycle_no = 0;

  framed_uart_pwm_dimmer dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .cmd(cmd), .rx_byte(rx_byte),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .kind(kind),
    .pwm_lines(pwm_lines), .tx_byte(tx_byte), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: random stall bursts, switched off in some windows.
  always @(negedge clk) begin
    cycle_no <= cycle_no + 1;
    if (stall_left != 0) begin
      rsp_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet_tail && (cycle_no / 64) % 3 != 1 && $urandom_range(0, 5) == 0) begin
      rsp_ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) sb.check_result(kind, pwm_lines, tx_byte, last);
      if (req_valid && req_ready) sb.note_request(cmd, rx_byte);
      if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("[framed_uart_pwm_dimmer] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic c, input logic [7:0] b);
    int gap;
    if (!quiet_tail && (n_sent / 40) % 3 != 2 && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    cmd       <= c;
    rx_byte   <= b;
    do @(posedge clk); while (!req_ready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_request(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Frame with a header, random levels and the given trailer; ticks may be slipped in before the level bytes.
  task automatic send_frame(input logic [7:0] trailer, input bit mix_ticks);
    send_request(CMD_BYTE, HDR_BYTE);
    for (int k = 0; k < LEVEL_N; k++) begin
      if (mix_ticks && $urandom_range(0, 3) == 0) send_ticks($urandom_range(1, 2));
      send_request(CMD_BYTE, pick_level());
    end
    send_request(CMD_BYTE, trailer);
  endtask

  // Hold the sender until every pending reply has been taken.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.expected_replies.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] bad;
    bit paused_mid;
    int pick;
    paused_mid = 1'b0;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Levels at reset value, then a wrong header byte.
    send_request(CMD_TICK, 8'hFF);
    send_request(CMD_BYTE, 8'h00);
    // Frame with extreme levels, then ticks against them.
    send_request(CMD_BYTE, HDR_BYTE);
    send_request(CMD_BYTE, 8'h00);
    send_request(CMD_BYTE, 8'hFF);
    send_request(CMD_BYTE, 8'h80);
    send_request(CMD_BYTE, 8'h7F);
    send_request(CMD_BYTE, TRL_BYTE);
    send_request(CMD_TICK, 8'h00);
    send_request(CMD_TICK, 8'h55);
    // Wrong trailer byte.
    send_request(CMD_BYTE, HDR_BYTE);
    send_request(CMD_BYTE, 8'h01);
    send_request(CMD_BYTE, 8'h02);
    send_request(CMD_BYTE, 8'h03);
    send_request(CMD_BYTE, 8'h04);
    send_request(CMD_BYTE, HDR_BYTE);
    // Tick in the middle of a frame leaves the frame position alone.
    send_request(CMD_BYTE, HDR_BYTE);
    send_request(CMD_BYTE, 8'hFF);
    send_request(CMD_TICK, 8'hAA);
    send_request(CMD_BYTE, 8'h00);
    send_request(CMD_BYTE, 8'h01);
    send_request(CMD_BYTE, 8'hFE);
    send_request(CMD_BYTE, TRL_BYTE);
    // Trailer value where a header is due.
    send_request(CMD_BYTE, TRL_BYTE);
    wait_drained();
    // One full phase period, so the phase wraps at least once.
    send_ticks(255);

    while (n_sent < ITEM_TARGET) begin
      if (n_sent >= QUIET_AFTER) quiet_tail = 1'b1;
      if (!paused_mid && n_sent >= 320) begin
        paused_mid = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_ticks($urandom_range(1, 12));
      end else if (pick < 85) begin
        send_frame(TRL_BYTE, 1'($urandom_range(0, 1)));
      end else if (pick < 93) begin
        do bad = 8'($urandom_range(0, 255)); while (bad == TRL_BYTE);
        send_frame(bad, 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 3)) send_request(CMD_BYTE, 8'($urandom_range(0, 255)));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d requests: %0d ticks, %0d phase wraps, %0d echoes, %0d rejects.",
             n_sent, sb.n_ticks, sb.n_wraps, sb.n_echoes, sb.n_rejects);
    $display("%0d results checked, %0d mismatches.", sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.expected_replies.size() == 0) begin
      $display("[framed_uart_pwm_dimmer] OK");
    end else begin
      $display("[framed_uart_pwm_dimmer] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fupwm_pkg.sv
hw/rtl/framed_uart_pwm_dimmer.sv
tb/sv/framed_uart_pwm_dimmer_test.sv
